// ----- hw/rtl/triangle_face_normal_assert.svh -----
// Assertion macros shared by the triangle face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TFN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TFN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFN_ASSERT_IMP(label, ante, cons, msg)
`define TFN_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/tfn_pkg.sv -----
// Package with the widths, pipeline positions and request/result types of the normal unit.
package tfn_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_WIDTH        = 16;

    localparam int TERM_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * TERM_WIDTH;
    localparam int NSUM_WIDTH  = PROD_WIDTH + 2;
    localparam int LEN_WIDTH   = $clog2(NSUM_WIDTH + 1);
    localparam int UNIT_WIDTH  = 31;
    localparam int USQ_WIDTH   = 2 * UNIT_WIDTH;
    localparam int SQ_WIDTH    = USQ_WIDTH + 2;
    localparam int ROOT_WIDTH  = SQ_WIDTH / 2;
    localparam int REM_WIDTH   = ROOT_WIDTH + 3;
    localparam int QUOT_WIDTH  = NORMAL_FRAC_BITS + 1;
    localparam int DIV_WIDTH   = UNIT_WIDTH + NORMAL_FRAC_BITS + 2;
    localparam int WIDE_WIDTH  = QUOT_WIDTH + OUT_WIDTH;

    localparam int RT_BASE    = 7;
    localparam int DV_BASE    = RT_BASE + ROOT_WIDTH + 1;
    localparam int OUT_POS    = DV_BASE + QUOT_WIDTH + 1;
    localparam int PIPE_DEPTH = OUT_POS + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } tri_req_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] nx;
        logic signed [OUT_WIDTH-1:0] ny;
        logic signed [OUT_WIDTH-1:0] nz;
        logic                        degenerate;
    } tri_res_t;

endpackage

// ----- hw/rtl/triangle_face_normal.sv -----
// Pipelined triangle face normal unit: Newell sums, normalization and Q1.14 output.
//
// A request carries the three vertices of a triangle in signed Q12.12 on req
// and is taken at a rising edge where start is high and busy is low. Busy is
// always low, so a new triangle may be issued in every cycle.
// Each request yields exactly one result on the result port, marked by done
// for a single cycle, in request order. The receiver cannot hold results off.
// The pipeline has 8 stages of products, sums and scaling, 32 square root
// stages that retire one root bit each, 16 divider stages (one that forms the
// dividend and 15 that each produce one quotient bit) and the output register.
// Throughput is one triangle per cycle.
// A triangle with a zero Newell sum gives zero components with degenerate set.
// Reset clears all valid bits, so no result is shown until new requests pass
// through; data registers are not reset.

`include "triangle_face_normal_assert.svh"

module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  tri_req_t req,
    output logic     busy,
    output logic     done,
    output tri_res_t result
);

    logic                          vld_reg  [PIPE_DEPTH];
    logic                          vld_next [PIPE_DEPTH];

    logic signed [TERM_WIDTH-1:0]  dif_reg  [3][3];
    logic signed [TERM_WIDTH-1:0]  dif_next [3][3];
    logic signed [TERM_WIDTH-1:0]  sum_reg  [3][3];
    logic signed [TERM_WIDTH-1:0]  sum_next [3][3];
    logic signed [PROD_WIDTH-1:0]  prod_reg [3][3];
    logic signed [PROD_WIDTH-1:0]  prod_next[3][3];
    logic signed [NSUM_WIDTH-1:0]  nsum_reg [3];
    logic signed [NSUM_WIDTH-1:0]  nsum_next[3];
    logic        [NSUM_WIDTH-1:0]  mag_reg  [3];
    logic        [NSUM_WIDTH-1:0]  mag_next [3];
    logic        [NSUM_WIDTH-1:0]  mags_reg [3];
    logic        [2:0]             neg4_reg;
    logic        [2:0]             neg5_reg;
    logic        [2:0]             neg6_reg;
    logic        [2:0]             neg7_reg;
    logic        [2:0]             neg_next;
    logic        [LEN_WIDTH-1:0]   blen_reg;
    logic        [LEN_WIDTH-1:0]   blen_next;
    logic                          degen6_reg;
    logic                          degen7_reg;
    logic        [UNIT_WIDTH-1:0]  u6_reg   [3];
    logic        [UNIT_WIDTH-1:0]  u6_next  [3];
    logic        [UNIT_WIDTH-1:0]  u7_reg   [3];
    logic        [USQ_WIDTH-1:0]   usq_reg  [3];
    logic        [USQ_WIDTH-1:0]   usq_next [3];

    logic        [SQ_WIDTH-1:0]    rad_reg  [ROOT_WIDTH+1];
    logic        [SQ_WIDTH-1:0]    rad_next [ROOT_WIDTH+1];
    logic        [REM_WIDTH-1:0]   rem_reg  [ROOT_WIDTH+1];
    logic        [REM_WIDTH-1:0]   rem_next [ROOT_WIDTH+1];
    logic        [ROOT_WIDTH-1:0]  root_reg [ROOT_WIDTH+1];
    logic        [ROOT_WIDTH-1:0]  root_next[ROOT_WIDTH+1];
    logic        [UNIT_WIDTH-1:0]  ru_reg   [ROOT_WIDTH+1][3];
    logic        [2:0]             rneg_reg [ROOT_WIDTH+1];
    logic                          rdeg_reg [ROOT_WIDTH+1];

    logic        [DIV_WIDTH-1:0]   drem_reg [QUOT_WIDTH+1][3];
    logic        [DIV_WIDTH-1:0]   drem_next[QUOT_WIDTH+1][3];
    logic        [QUOT_WIDTH-1:0]  quo_reg  [QUOT_WIDTH+1][3];
    logic        [QUOT_WIDTH-1:0]  quo_next [QUOT_WIDTH+1][3];
    logic        [DIV_WIDTH-1:0]   den_reg  [QUOT_WIDTH+1];
    logic        [2:0]             dneg_reg [QUOT_WIDTH+1];
    logic                          ddeg_reg [QUOT_WIDTH+1];

    tri_res_t                      res_reg;
    tri_res_t                      res_next;

    assign busy   = 1'b0;
    assign done   = vld_reg[OUT_POS];
    assign result = res_reg;

    always_comb
    begin
        vld_next[0] = start && !busy;
        for (int p = 1; p < PIPE_DEPTH; p++)
        begin
            vld_next[p] = vld_reg[p-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PIPE_DEPTH; p++)
            begin
                vld_reg[p] <= 1'b0;
            end
        end
        else
        begin
            for (int p = 0; p < PIPE_DEPTH; p++)
            begin
                vld_reg[p] <= vld_next[p];
            end
        end
    end

    // Component k uses the difference of axis k+1 and the sum of axis k+2 along each edge.
    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] vert [3][3];
        vert[0][0] = req.ax;
        vert[0][1] = req.ay;
        vert[0][2] = req.az;
        vert[1][0] = req.bx;
        vert[1][1] = req.by;
        vert[1][2] = req.bz;
        vert[2][0] = req.cx;
        vert[2][1] = req.cy;
        vert[2][2] = req.cz;
        for (int k = 0; k < 3; k++)
        begin
            for (int e = 0; e < 3; e++)
            begin
                dif_next[k][e] = TERM_WIDTH'(vert[e][(k+1)%3])
                               - TERM_WIDTH'(vert[(e+1)%3][(k+1)%3]);
                sum_next[k][e] = TERM_WIDTH'(vert[e][(k+2)%3])
                               + TERM_WIDTH'(vert[(e+1)%3][(k+2)%3]);
            end
        end
    end

    always_comb
    begin
        logic [NSUM_WIDTH-1:0] all_bits;
        logic [NSUM_WIDTH+UNIT_WIDTH-1:0] ext;
        for (int k = 0; k < 3; k++)
        begin
            for (int e = 0; e < 3; e++)
            begin
                prod_next[k][e] = PROD_WIDTH'(dif_reg[k][e] * sum_reg[k][e]);
            end
            nsum_next[k] = NSUM_WIDTH'(prod_reg[k][0]) + NSUM_WIDTH'(prod_reg[k][1])
                         + NSUM_WIDTH'(prod_reg[k][2]);
            neg_next[k] = nsum_reg[k][NSUM_WIDTH-1];
            mag_next[k] = nsum_reg[k][NSUM_WIDTH-1] ? NSUM_WIDTH'(-nsum_reg[k])
                                                     : NSUM_WIDTH'(nsum_reg[k]);
            ext = {mags_reg[k], {UNIT_WIDTH{1'b0}}} >> blen_reg;
            u6_next[k] = ext[UNIT_WIDTH-1:0];
            usq_next[k] = USQ_WIDTH'(u6_reg[k] * u6_reg[k]);
        end
        all_bits = mag_reg[0] | mag_reg[1] | mag_reg[2];
        blen_next = '0;
        for (int b = 0; b < NSUM_WIDTH; b++)
        begin
            if (all_bits[b])
            begin
                blen_next = LEN_WIDTH'(b + 1);
            end
        end
    end

    // Square root, one root bit per stage; stage 0 holds the sum of squares.
    always_comb
    begin
        logic [REM_WIDTH-1:0] shifted;
        logic [REM_WIDTH-1:0] trial;
        rad_next[0]  = SQ_WIDTH'(usq_reg[0]) + SQ_WIDTH'(usq_reg[1]) + SQ_WIDTH'(usq_reg[2]);
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int j = 1; j <= ROOT_WIDTH; j++)
        begin
            shifted = {rem_reg[j-1][REM_WIDTH-3:0], rad_reg[j-1][SQ_WIDTH-1:SQ_WIDTH-2]};
            trial   = {1'b0, root_reg[j-1], 2'b01};
            rad_next[j] = {rad_reg[j-1][SQ_WIDTH-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next[j]  = shifted - trial;
                root_next[j] = {root_reg[j-1][ROOT_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = shifted;
                root_next[j] = {root_reg[j-1][ROOT_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb
    begin
        logic [DIV_WIDTH-1:0] step_den;
        for (int k = 0; k < 3; k++)
        begin
            drem_next[0][k] = (DIV_WIDTH'(ru_reg[ROOT_WIDTH][k]) << (NORMAL_FRAC_BITS + 1))
                            + DIV_WIDTH'(root_reg[ROOT_WIDTH]);
            quo_next[0][k]  = '0;
            for (int j = 1; j <= QUOT_WIDTH; j++)
            begin
                step_den = den_reg[j-1] << (QUOT_WIDTH - j);
                if (drem_reg[j-1][k] >= step_den)
                begin
                    drem_next[j][k] = drem_reg[j-1][k] - step_den;
                    quo_next[j][k]  = quo_reg[j-1][k] | (QUOT_WIDTH'(1) << (QUOT_WIDTH - j));
                end
                else
                begin
                    drem_next[j][k] = drem_reg[j-1][k];
                    quo_next[j][k]  = quo_reg[j-1][k];
                end
            end
        end
    end

    always_comb
    begin
        logic [QUOT_WIDTH-1:0]        mag_q;
        logic signed [WIDE_WIDTH-1:0] wide;
        logic signed [OUT_WIDTH-1:0]  comp [3];
        for (int k = 0; k < 3; k++)
        begin
            mag_q = quo_reg[QUOT_WIDTH][k];
            if (mag_q > (QUOT_WIDTH'(1) << NORMAL_FRAC_BITS))
            begin
                mag_q = QUOT_WIDTH'(1) << NORMAL_FRAC_BITS;
            end
            wide = $signed({{OUT_WIDTH{1'b0}}, mag_q});
            if (dneg_reg[QUOT_WIDTH][k])
            begin
                wide = -wide;
            end
            if (wide > $signed(WIDE_WIDTH'((1 << (OUT_WIDTH - 1)) - 1)))
            begin
                wide = $signed(WIDE_WIDTH'((1 << (OUT_WIDTH - 1)) - 1));
            end
            if (wide < -$signed(WIDE_WIDTH'(1 << (OUT_WIDTH - 1))))
            begin
                wide = -$signed(WIDE_WIDTH'(1 << (OUT_WIDTH - 1)));
            end
            comp[k] = ddeg_reg[QUOT_WIDTH] ? '0 : wide[OUT_WIDTH-1:0];
        end
        res_next.nx         = comp[0];
        res_next.ny         = comp[1];
        res_next.nz         = comp[2];
        res_next.degenerate = ddeg_reg[QUOT_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int e = 0; e < 3; e++)
            begin
                dif_reg[k][e]  <= dif_next[k][e];
                sum_reg[k][e]  <= sum_next[k][e];
                prod_reg[k][e] <= prod_next[k][e];
            end
            nsum_reg[k] <= nsum_next[k];
            mag_reg[k]  <= mag_next[k];
            mags_reg[k] <= mag_reg[k];
            u6_reg[k]   <= u6_next[k];
            u7_reg[k]   <= u6_reg[k];
            usq_reg[k]  <= usq_next[k];
        end
        neg4_reg   <= neg_next;
        neg5_reg   <= neg4_reg;
        neg6_reg   <= neg5_reg;
        neg7_reg   <= neg6_reg;
        blen_reg   <= blen_next;
        degen6_reg <= (blen_reg == '0);
        degen7_reg <= degen6_reg;

        for (int j = 0; j <= ROOT_WIDTH; j++)
        begin
            rad_reg[j]  <= rad_next[j];
            rem_reg[j]  <= rem_next[j];
            root_reg[j] <= root_next[j];
        end
        ru_reg[0]   <= u7_reg;
        rneg_reg[0] <= neg7_reg;
        rdeg_reg[0] <= degen7_reg;
        for (int j = 1; j <= ROOT_WIDTH; j++)
        begin
            ru_reg[j]   <= ru_reg[j-1];
            rneg_reg[j] <= rneg_reg[j-1];
            rdeg_reg[j] <= rdeg_reg[j-1];
        end

        for (int j = 0; j <= QUOT_WIDTH; j++)
        begin
            drem_reg[j] <= drem_next[j];
            quo_reg[j]  <= quo_next[j];
        end
        den_reg[0]  <= DIV_WIDTH'({root_reg[ROOT_WIDTH], 1'b0});
        dneg_reg[0] <= rneg_reg[ROOT_WIDTH];
        ddeg_reg[0] <= rdeg_reg[ROOT_WIDTH];
        for (int j = 1; j <= QUOT_WIDTH; j++)
        begin
            den_reg[j]  <= den_reg[j-1];
            dneg_reg[j] <= dneg_reg[j-1];
            ddeg_reg[j] <= ddeg_reg[j-1];
        end
        res_reg <= res_next;
    end

    `TFN_ASSERT_IMP(a_degen_zero, done && result.degenerate, (result.nx == '0) && (result.ny == '0) && (result.nz == '0), "degenerate result with nonzero components")
    `TFN_ASSERT_IMP(a_sq_range, vld_reg[RT_BASE] && !rdeg_reg[0], rad_reg[0][SQ_WIDTH-1:SQ_WIDTH-4] != '0, "sum of squares below scaled range")
    `TFN_ASSERT_IMP(a_root_range, vld_reg[DV_BASE-1] && !rdeg_reg[ROOT_WIDTH], root_reg[ROOT_WIDTH][ROOT_WIDTH-1:ROOT_WIDTH-2] != '0, "vector length below scaled range")
    `TFN_ASSERT_NXT(a_div_to_out, vld_reg[OUT_POS-1], done && (result.degenerate == $past(ddeg_reg[QUOT_WIDTH])), "divider output not delivered")

endmodule
